@@ hw/rtl/jp2_box_metadata_locator_top_assert.svh @@
// assertion macros for the jp2 box metadata locator
// depends on a clock named clock and a reset named reset in the including module
`ifndef JP2_BOX_METADATA_LOCATOR_TOP_ASSERT_SVH
`define JP2_BOX_METADATA_LOCATOR_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define JBML_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define JBML_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/jp2bml_pkg.sv @@
// types and constants for the jp2 box metadata locator
// no dependencies
package jp2bml_pkg;

   typedef enum logic [2:0] {
      PH_SIG  = 3'd0,
      PH_HDR  = 3'd1,
      PH_SUB  = 3'd2,
      PH_IHDR = 3'd3,
      PH_UUID = 3'd4,
      PH_SKIP = 3'd5
   } phase_type;

   localparam logic [2:0] EV_NONE    = 3'd0;
   localparam logic [2:0] EV_NOT_JP2 = 3'd1;
   localparam logic [2:0] EV_SIZE    = 3'd2;
   localparam logic [2:0] EV_EXIF    = 3'd3;
   localparam logic [2:0] EV_IPTC    = 3'd4;
   localparam logic [2:0] EV_XMP     = 3'd5;
   localparam logic [2:0] EV_END     = 3'd6;
   localparam logic [2:0] EV_BAD_LEN = 3'd7;

   localparam logic [31:0] TYPE_JP2H = 32'h6a703268;
   localparam logic [31:0] TYPE_IHDR = 32'h69686472;
   localparam logic [31:0] TYPE_UUID = 32'h75756964;

   localparam logic [4:0] SIG_LEN = 5'd12;

   localparam logic [7:0] UUID_EXIF [16] = '{
      8'h4a, 8'h70, 8'h67, 8'h54, 8'h69, 8'h66, 8'h66, 8'h45,
      8'h78, 8'h69, 8'h66, 8'h2d, 8'h3e, 8'h4a, 8'h50, 8'h32
   };
   localparam logic [7:0] UUID_IPTC [16] = '{
      8'h33, 8'hc7, 8'ha4, 8'hd2, 8'hb8, 8'h1d, 8'h47, 8'h23,
      8'ha0, 8'hba, 8'hf1, 8'ha3, 8'he0, 8'h97, 8'had, 8'h38
   };
   localparam logic [7:0] UUID_XMP [16] = '{
      8'hbe, 8'h7a, 8'hcf, 8'hcb, 8'h97, 8'ha9, 8'h42, 8'he8,
      8'h9c, 8'h71, 8'h99, 8'h94, 8'h91, 8'he3, 8'haf, 8'hac
   };

   function automatic logic [7:0] sig_byte(input logic [3:0] idx);
      logic [7:0] val;
      unique case (idx)
         4'd3:    val = 8'h0c;
         4'd4:    val = 8'h6a;
         4'd5:    val = 8'h50;
         4'd6:    val = 8'h20;
         4'd7:    val = 8'h20;
         4'd8:    val = 8'h0d;
         4'd9:    val = 8'h0a;
         4'd10:   val = 8'h87;
         4'd11:   val = 8'h0a;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

@@ hw/rtl/jp2_box_metadata_locator_top.sv @@
// jp2 box walker: each input byte passes the input register, then the result register;
// 1 byte per cycle while rsp_stall does not hold the result register, one result per byte
// all parsing is one combinational pass from the input register into the result register
// synchronous active-high reset returns the parser to signature check at offset zero;
// a byte with file_start set restarts parsing in the same pass
// uses jp2bml_pkg and jp2_box_metadata_locator_top_assert.svh
`include "jp2_box_metadata_locator_top_assert.svh"

module jp2_box_metadata_locator_top #(
   parameter int OFFSET_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_file_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_res,
   output logic [31:0] rsp_image_width,
   output logic [31:0] rsp_image_height,
   output logic [31:0] rsp_payload_offset,
   output logic [31:0] rsp_payload_length
);

   localparam int P = OFFSET_BITS;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_start_ff;
   logic       accept, advance;

   jp2bml_pkg::phase_type ph_ff, ph_in, ph_cur, ph_eff;
   logic [4:0]   k_ff, k_in, k_cur, k_eff;
   logic [P-1:0] pos_ff, pos_in, pos_cur;
   logic [P-1:0] bstart_ff, bstart_in, bstart_cur, bstart_eff;
   logic [P-1:0] off_w, pay_off_w;
   logic [63:0]  pay_off_ext;
   logic [31:0]  bsize_ff, bsize_in, bsize_cur;
   logic [31:0]  acc_ff, acc_in, acc_cur, acc_shift;
   logic [31:0]  hh_ff, hh_in, hh_cur;
   logic [2:0]   cand_ff, cand_in, cand_cur, cand_miss;
   logic         halt_ff, halt_in, halt_cur;
   logic         box_end, overrun;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  ev_ff, ev_in;
   logic [31:0] width_ff, width_in, height_ff, height_in;
   logic [31:0] offset_ff, offset_in, length_ff, length_in;

   // handshake
   assign advance     = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff  <= req_data_byte;
         in_start_ff <= req_file_start;
      end
      if (advance) begin
         ev_ff     <= ev_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         offset_ff <= offset_in;
         length_ff <= length_in;
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff     <= jp2bml_pkg::PH_SIG;
         k_ff      <= '0;
         pos_ff    <= '0;
         bstart_ff <= '0;
         bsize_ff  <= '0;
         acc_ff    <= '0;
         cand_ff   <= 3'b111;
         hh_ff     <= '0;
         halt_ff   <= 1'b0;
      end else if (advance) begin
         ph_ff     <= ph_in;
         k_ff      <= k_in;
         pos_ff    <= pos_in;
         bstart_ff <= bstart_in;
         bsize_ff  <= bsize_in;
         acc_ff    <= acc_in;
         cand_ff   <= cand_in;
         hh_ff     <= hh_in;
         halt_ff   <= halt_in;
      end
   end

   // state as seen by this byte, after a possible restart
   always_comb begin
      if (in_start_ff) begin
         ph_cur     = jp2bml_pkg::PH_SIG;
         k_cur      = '0;
         pos_cur    = '0;
         bstart_cur = '0;
         bsize_cur  = '0;
         acc_cur    = '0;
         cand_cur   = 3'b111;
         hh_cur     = '0;
         halt_cur   = 1'b0;
      end else begin
         ph_cur     = ph_ff;
         k_cur      = k_ff;
         pos_cur    = pos_ff;
         bstart_cur = bstart_ff;
         bsize_cur  = bsize_ff;
         acc_cur    = acc_ff;
         cand_cur   = cand_ff;
         hh_cur     = hh_ff;
         halt_cur   = halt_ff;
      end
   end

   // box boundary
   assign off_w   = pos_cur - bstart_cur;
   assign box_end = (ph_cur == jp2bml_pkg::PH_SUB || ph_cur == jp2bml_pkg::PH_IHDR ||
                     ph_cur == jp2bml_pkg::PH_UUID || ph_cur == jp2bml_pkg::PH_SKIP) &&
                    (64'(off_w) == 64'(bsize_cur));
   assign overrun    = box_end && (ph_cur != jp2bml_pkg::PH_SKIP);
   assign ph_eff     = box_end ? jp2bml_pkg::PH_HDR : ph_cur;
   assign k_eff      = box_end ? 5'd0 : k_cur;
   assign bstart_eff = box_end ? pos_cur : bstart_cur;

   assign acc_shift   = {acc_cur[23:0], in_byte_ff};
   assign pay_off_w   = bstart_eff + P'(24);
   assign pay_off_ext = 64'(pay_off_w);
   assign cand_miss[0] = in_byte_ff != jp2bml_pkg::UUID_EXIF[k_eff[3:0]];
   assign cand_miss[1] = in_byte_ff != jp2bml_pkg::UUID_IPTC[k_eff[3:0]];
   assign cand_miss[2] = in_byte_ff != jp2bml_pkg::UUID_XMP[k_eff[3:0]];

   always_comb begin
      ph_in     = ph_cur;
      k_in      = k_cur;
      pos_in    = pos_cur + P'(1);
      bstart_in = bstart_cur;
      bsize_in  = bsize_cur;
      acc_in    = acc_cur;
      cand_in   = cand_cur;
      hh_in     = hh_cur;
      halt_in   = halt_cur;
      ev_in     = jp2bml_pkg::EV_NONE;
      width_in  = '0;
      height_in = '0;
      offset_in = '0;
      length_in = '0;
      priority if (halt_cur) begin
         ev_in = jp2bml_pkg::EV_NONE;
      end else if (overrun) begin
         ev_in   = jp2bml_pkg::EV_BAD_LEN;
         halt_in = 1'b1;
      end else begin
         ph_in     = ph_eff;
         k_in      = k_eff;
         bstart_in = bstart_eff;
         unique case (ph_eff)
            jp2bml_pkg::PH_SIG: begin
               priority if (k_eff >= jp2bml_pkg::SIG_LEN ||
                            in_byte_ff != jp2bml_pkg::sig_byte(k_eff[3:0])) begin
                  ev_in   = jp2bml_pkg::EV_NOT_JP2;
                  halt_in = 1'b1;
               end else if (k_eff == jp2bml_pkg::SIG_LEN - 5'd1) begin
                  ph_in     = jp2bml_pkg::PH_HDR;
                  k_in      = '0;
                  bstart_in = pos_cur + P'(1);
               end else begin
                  k_in = k_eff + 5'd1;
               end
            end
            jp2bml_pkg::PH_HDR: begin
               acc_in = acc_shift;
               if (k_eff == 5'd3) begin
                  bsize_in = acc_shift;
               end
               priority if (k_eff < 5'd7) begin
                  k_in = k_eff + 5'd1;
               end else begin
                  k_in = '0;
                  priority if (bsize_cur == 32'd0) begin
                     ev_in   = jp2bml_pkg::EV_END;
                     halt_in = 1'b1;
                  end else if (bsize_cur < 32'd8) begin
                     ev_in   = jp2bml_pkg::EV_BAD_LEN;
                     halt_in = 1'b1;
                  end else if (acc_shift == jp2bml_pkg::TYPE_JP2H) begin
                     ph_in = jp2bml_pkg::PH_SUB;
                  end else if (acc_shift == jp2bml_pkg::TYPE_UUID) begin
                     ph_in   = jp2bml_pkg::PH_UUID;
                     cand_in = 3'b111;
                  end else begin
                     ph_in = jp2bml_pkg::PH_SKIP;
                  end
               end
            end
            jp2bml_pkg::PH_SUB: begin
               acc_in = acc_shift;
               priority if (k_eff < 5'd7) begin
                  k_in = k_eff + 5'd1;
               end else begin
                  k_in  = '0;
                  ph_in = (acc_shift == jp2bml_pkg::TYPE_IHDR) ? jp2bml_pkg::PH_IHDR
                                                               : jp2bml_pkg::PH_SKIP;
               end
            end
            jp2bml_pkg::PH_IHDR: begin
               if (k_eff < 5'd8) begin
                  acc_in = acc_shift;
               end
               if (k_eff == 5'd3) begin
                  hh_in = acc_shift;
               end
               priority if (k_eff < 5'd13) begin
                  k_in = k_eff + 5'd1;
               end else begin
                  k_in      = '0;
                  ph_in     = jp2bml_pkg::PH_SKIP;
                  ev_in     = jp2bml_pkg::EV_SIZE;
                  width_in  = acc_cur;
                  height_in = hh_cur;
               end
            end
            jp2bml_pkg::PH_UUID: begin
               if (k_eff < 5'd16) begin
                  cand_in = cand_cur & ~cand_miss;
               end
               priority if (k_eff < 5'd15) begin
                  k_in = k_eff + 5'd1;
               end else begin
                  k_in  = '0;
                  ph_in = jp2bml_pkg::PH_SKIP;
                  if (cand_in != 3'b000) begin
                     priority if (cand_in[0]) begin
                        ev_in = jp2bml_pkg::EV_EXIF;
                     end else if (cand_in[1]) begin
                        ev_in = jp2bml_pkg::EV_IPTC;
                     end else begin
                        ev_in = jp2bml_pkg::EV_XMP;
                     end
                     offset_in = pay_off_ext[31:0];
                     length_in = bsize_cur - 32'd24;
                  end
               end
            end
            default: begin
               ph_in = ph_eff;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_res      = ev_ff;
   assign rsp_image_width    = width_ff;
   assign rsp_image_height   = height_ff;
   assign rsp_payload_offset = offset_ff;
   assign rsp_payload_length = length_ff;

   `JBML_ASSERT_NEXT(a_halt_quiet, advance && halt_ff && !in_start_ff,
      ev_ff == jp2bml_pkg::EV_NONE, "byte after halt produced an event")
   `JBML_ASSERT_NEXT(a_stop_halts,
      advance && (ev_in == jp2bml_pkg::EV_NOT_JP2 || ev_in == jp2bml_pkg::EV_END ||
                  ev_in == jp2bml_pkg::EV_BAD_LEN),
      halt_ff, "terminal event without halt")
   `JBML_ASSERT_NOW(a_hdr_count,
      ph_ff == jp2bml_pkg::PH_HDR || ph_ff == jp2bml_pkg::PH_SUB,
      k_ff < 5'd8, "header byte count out of range")
   `JBML_ASSERT_NEXT(a_input_held, in_valid_ff && !advance,
      in_valid_ff && $stable(in_byte_ff), "stalled input register lost its byte")

endmodule
